// ===== hw/rtl/dla_particle_stick_check_core_macros.svh =====
// assertion macros for the particle stick check core
// expects clk and rst_n in the scope of each use
`ifndef DLA_PARTICLE_STICK_CHECK_CORE_MACROS_SVH
`define DLA_PARTICLE_STICK_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define DPSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dpsc_pkg.sv =====
// shared types and constants for the particle stick check core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpsc_pkg;

    localparam int GRID_W   = 512;
    localparam int GRID_H   = 512;
    localparam int COORD_W  = 9;
    localparam int ROW_AW   = $clog2(GRID_H);
    localparam int RAD_W    = 10;
    localparam int OUTER_W  = 11;
    localparam int CNT_W    = 19;
    localparam int RING_W   = 8;
    localparam int SQ_W     = 19;
    localparam int CFG_W    = 19;

    localparam logic [COORD_W-1:0] CENTRE_X = COORD_W'(GRID_W / 2);
    localparam logic [COORD_W-1:0] CENTRE_Y = COORD_W'(GRID_H / 2);
    localparam logic [COORD_W-1:0] X_LIMIT  = COORD_W'(GRID_W - 1);
    localparam logic [COORD_W-1:0] Y_LIMIT  = COORD_W'(GRID_H - 1);
    localparam logic [ROW_AW-1:0]  SEED_ROW = ROW_AW'(GRID_H / 2);
    localparam logic [ROW_AW-1:0]  LAST_ROW = ROW_AW'(GRID_H - 1);
    localparam logic [GRID_W-1:0]  SEED_BITS = GRID_W'(1) << (GRID_W / 2);

    localparam logic [RAD_W-1:0]  RADIUS_MAX        = RAD_W'(1023);
    localparam logic [RAD_W-1:0]  RADIUS_RESET      = RAD_W'(1);
    localparam logic [RING_W-1:0] RING_RESET        = RING_W'(7);
    localparam logic [CNT_W-1:0]  MAX_CLUSTER_RESET = CNT_W'(250000);

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_STUCK  = 2'd1,
        ST_OOB    = 2'd2,
        ST_HALTED = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_RING_WIDTH  = 1'b0,
        REG_MAX_CLUSTER = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [RAD_W-1:0]   cluster_radius;
        logic [OUTER_W-1:0] spawn_outer;
        logic [CNT_W-1:0]   stuck_count;
    } out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RD_UP,
        S_RD_MID,
        S_RD_DN,
        S_CAP_DN,
        S_DECIDE,
        S_WRITE,
        S_SQRT,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic check;
        logic rd_up;
        logic rd_dn;
        logic cap_up;
        logic cap_mid;
        logic cap_dn;
        logic write_cell;
        logic sqrt_step;
        logic update_radius;
        logic load_result;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic reject;
        logic touch;
        logic sqrt_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpsc_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dpsc_ctrl.sv =====
// sequencing state machine for the particle stick check core
// depends on dpsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dpsc_pkg::dp_stat_t stat,
    output logic                    busy,
    output dpsc_pkg::ctl_cmd_t      cmd
);

    import dpsc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   state_next = stat.clear_last ? S_IDLE : S_CLEAR;
            S_IDLE:    state_next = start ? S_CHECK : S_IDLE;
            S_CHECK:   state_next = stat.reject ? S_DONE : S_RD_UP;
            S_RD_UP:   state_next = S_RD_MID;
            S_RD_MID:  state_next = S_RD_DN;
            S_RD_DN:   state_next = S_CAP_DN;
            S_CAP_DN:  state_next = S_DECIDE;
            S_DECIDE:  state_next = stat.touch ? S_WRITE : S_DONE;
            S_WRITE:   state_next = S_SQRT;
            S_SQRT:    state_next = stat.sqrt_last ? S_UPDATE : S_SQRT;
            S_UPDATE:  state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_CLEAR:   cmd.clear_step = 1'b1;
            S_IDLE:
            begin
                busy          = 1'b0;
                cmd.load_item = start;
            end
            S_CHECK:   cmd.check = 1'b1;
            S_RD_UP:   cmd.rd_up = 1'b1;
            S_RD_MID:  cmd.cap_up = 1'b1;
            S_RD_DN:
            begin
                cmd.rd_dn   = 1'b1;
                cmd.cap_mid = 1'b1;
            end
            S_CAP_DN:  cmd.cap_dn = 1'b1;
            S_DECIDE:  cmd = '0;
            S_WRITE:   cmd.write_cell = 1'b1;
            S_SQRT:    cmd.sqrt_step = 1'b1;
            S_UPDATE:  cmd.update_radius = 1'b1;
            S_DONE:    cmd.load_result = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dpsc_datapath.sv =====
// bitmap, neighbour test, iterative square root and result registers
// depends on dpsc_pkg and dpsc_ram
`timescale 1ns / 1ps
`default_nettype none

module dpsc_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dpsc_pkg::ctl_cmd_t     cmd,
    input  wire dpsc_pkg::in_t          walker,
    input  wire logic                   cfg_we,
    input  wire dpsc_pkg::cfg_index_t   cfg_index,
    input  wire logic [dpsc_pkg::CFG_W-1:0] cfg_data,
    output dpsc_pkg::dp_stat_t          stat,
    output logic                        done,
    output dpsc_pkg::out_t              report
);

    import dpsc_pkg::*;

    // control state
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic              done_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [CNT_W-1:0]  attached_reg;
    logic [RING_W-1:0] ring_reg;
    logic [CNT_W-1:0]  max_cluster_reg;

    // payload
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    status_t            status_reg;
    logic [2:0]         up_bits_reg;
    logic [1:0]         mid_bits_reg;
    logic [2:0]         dn_bits_reg;
    logic [GRID_W-1:0]  mid_row_reg;
    logic [SQ_W-2:0]    sq_x_reg;
    logic [SQ_W-2:0]    sq_y_reg;
    logic [SQ_W-1:0]    v_reg;
    logic [SQ_W-1:0]    res_reg;
    logic [SQ_W-1:0]    bit_reg;
    out_t               report_reg;

    logic [SQ_W-1:0]    v_next;
    logic [SQ_W-1:0]    res_next;
    logic [SQ_W-1:0]    bit_next;
    logic [RAD_W-1:0]   radius_next;

    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               halted;
    logic               oob;
    logic [SQ_W:0]      trial;
    logic [RAD_W-1:0]   root;
    logic [RAD_W:0]     root_inc;

    logic              ram_we;
    logic [ROW_AW-1:0] ram_addr;
    logic [GRID_W-1:0] ram_wdata;
    logic [GRID_W-1:0] ram_rdata;

    dpsc_ram #(
        .WIDTH (GRID_W),
        .DEPTH (GRID_H)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign x_lo = x_reg - COORD_W'(1);
    assign x_hi = x_reg + COORD_W'(1);
    assign dx   = (x_reg > CENTRE_X) ? (x_reg - CENTRE_X) : (CENTRE_X - x_reg);
    assign dy   = (y_reg > CENTRE_Y) ? (y_reg - CENTRE_Y) : (CENTRE_Y - y_reg);

    assign halted = attached_reg >= max_cluster_reg;
    assign oob    = (x_reg == '0) || (x_reg >= X_LIMIT) ||
                    (y_reg == '0) || (y_reg >= Y_LIMIT);

    assign ram_we = cmd.clear_step || cmd.write_cell;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_addr  = clr_cnt_reg;
            ram_wdata = (clr_cnt_reg == SEED_ROW) ? SEED_BITS : '0;
        end
        else
        begin
            ram_wdata = mid_row_reg | (GRID_W'(1) << x_reg);
            if (cmd.rd_up)
            begin
                ram_addr = ROW_AW'(y_reg - COORD_W'(1));
            end
            else if (cmd.rd_dn)
            begin
                ram_addr = ROW_AW'(y_reg + COORD_W'(1));
            end
            else
            begin
                ram_addr = ROW_AW'(y_reg);
            end
        end
    end

    // one digit pair of the square root per step
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.write_cell)
        begin
            v_next   = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
            res_next = '0;
            bit_next = {1'b1, {(SQ_W-1){1'b0}}};
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[SQ_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    assign root     = res_reg[RAD_W-1:0];
    assign root_inc = {1'b0, root} + (RAD_W+1)'(1);

    always_comb
    begin
        radius_next = radius_reg;
        if (cmd.update_radius && (root > radius_reg))
        begin
            radius_next = (root_inc > {1'b0, RADIUS_MAX}) ? RADIUS_MAX : root_inc[RAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            radius_reg      <= RADIUS_RESET;
            attached_reg    <= '0;
            ring_reg        <= RING_RESET;
            max_cluster_reg <= MAX_CLUSTER_RESET;
        end
        else
        begin
            done_reg   <= cmd.load_result;
            radius_reg <= radius_next;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
            if (cmd.write_cell)
            begin
                attached_reg <= attached_reg + CNT_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RING_WIDTH:  ring_reg        <= cfg_data[RING_W-1:0];
                    REG_MAX_CLUSTER: max_cluster_reg <= cfg_data[CNT_W-1:0];
                    default:         ring_reg        <= ring_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (cmd.load_item)
        begin
            x_reg <= walker.pos_x;
            y_reg <= walker.pos_y;
        end
        if (cmd.check)
        begin
            status_reg <= halted ? ST_HALTED : (oob ? ST_OOB : ST_FREE);
        end
        else if (cmd.write_cell)
        begin
            status_reg <= ST_STUCK;
        end
        if (cmd.cap_up)
        begin
            up_bits_reg <= {ram_rdata[x_hi], ram_rdata[x_reg], ram_rdata[x_lo]};
        end
        if (cmd.cap_mid)
        begin
            mid_bits_reg <= {ram_rdata[x_hi], ram_rdata[x_lo]};
            mid_row_reg  <= ram_rdata;
        end
        if (cmd.cap_dn)
        begin
            dn_bits_reg <= {ram_rdata[x_hi], ram_rdata[x_reg], ram_rdata[x_lo]};
            sq_x_reg    <= (SQ_W-1)'(dx) * (SQ_W-1)'(dx);
            sq_y_reg    <= (SQ_W-1)'(dy) * (SQ_W-1)'(dy);
        end
        if (cmd.load_result)
        begin
            report_reg.status         <= status_reg;
            report_reg.cluster_radius <= radius_reg;
            report_reg.spawn_outer    <= {1'b0, radius_reg} + OUTER_W'(ring_reg);
            report_reg.stuck_count    <= attached_reg;
        end
    end

    assign stat.clear_last = cmd.clear_step && (clr_cnt_reg == LAST_ROW);
    assign stat.reject     = halted || oob;
    assign stat.touch      = (|up_bits_reg) || (|mid_bits_reg) || (|dn_bits_reg);
    assign stat.sqrt_last  = bit_reg[0];

    assign done   = done_reg;
    assign report = report_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dla_particle_stick_check_core.sv =====
// top level of the particle stick check core: controller plus datapath
// depends on dpsc_pkg, dpsc_ctrl, dpsc_datapath and the assertion macro header
//
//   channel   signals                         transfer
//   walker    start, busy, walker             edge with start high and busy low
//   report    done, report                    edge ending the single cycle done is high
//   config    cfg_we, cfg_index, cfg_data     edge with cfg_we high
//
// after reset the occupancy map is cleared one row a cycle, all 512 rows, busy high
// walker transfer to report transfer: a halted or out-of-bounds walker skips
// the map; a free one takes the three registered row reads of the map ram;
// a stuck one also writes its cell and runs the ten-step square root
// a new walker is taken while the previous result is on the report ports
// the receiver cannot stall; each result is shown for one cycle only
`timescale 1ns / 1ps
`default_nettype none
`include "dla_particle_stick_check_core_macros.svh"

module dla_particle_stick_check_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire dpsc_pkg::in_t              walker,
    input  wire logic                       cfg_we,
    input  wire dpsc_pkg::cfg_index_t       cfg_index,
    input  wire logic [dpsc_pkg::CFG_W-1:0] cfg_data,
    output logic                            done,
    output dpsc_pkg::out_t                  report
);

    import dpsc_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    dpsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    dpsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .walker    (walker),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .done      (done),
        .report    (report)
    );

    `DPSC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
    `DPSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "walker transfer did not raise busy")
    `DPSC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while the core is still busy")

endmodule

`default_nettype wire
